FILE: src/vector_angle_full_circle_defines.svh
`ifndef VECTOR_ANGLE_FULL_CIRCLE_DEFINES_SVH
`define VECTOR_ANGLE_FULL_CIRCLE_DEFINES_SVH
// same-cycle implication, checked out of reset
`define VAFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define VAFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: src/vafc_pkg.sv
package vafc_pkg;
  localparam int CordicStagesDef = 20;
  localparam int XW = 34;   // dot and cross, exact
  localparam int NW = 45;   // normalised cordic datapath
  localparam int ZW = 26;   // angle accumulator, 2^-16 degree
  localparam int KW = 6;    // normalisation shift amount
  localparam int NormBit = 40;
  localparam logic signed [ZW-1:0] AngQuarter = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] AngFull = ZW'(360 * 65536);
  localparam logic [16:0] OutFull = 17'd46080;

  typedef struct packed {
    logic valid;
    logic invalid;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = ZW'(2949120);
      5'd1: r = ZW'(1740967);
      5'd2: r = ZW'(919879);
      5'd3: r = ZW'(466945);
      5'd4: r = ZW'(234379);
      5'd5: r = ZW'(117304);
      5'd6: r = ZW'(58666);
      5'd7: r = ZW'(29335);
      5'd8: r = ZW'(14668);
      5'd9: r = ZW'(7334);
      5'd10: r = ZW'(3667);
      5'd11: r = ZW'(1833);
      5'd12: r = ZW'(917);
      5'd13: r = ZW'(458);
      5'd14: r = ZW'(229);
      5'd15: r = ZW'(115);
      5'd16: r = ZW'(57);
      5'd17: r = ZW'(29);
      5'd18: r = ZW'(14);
      5'd19: r = ZW'(7);
      5'd20: r = ZW'(4);
      5'd21: r = ZW'(2);
      5'd22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

FILE: src/vafc_front.sv
module vafc_front import vafc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [15:0]   ax,
  input  logic signed [15:0]   ay,
  input  logic signed [15:0]   bx,
  input  logic signed [15:0]   by,
  output ctl_t                 ctl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  ctl_t c1_r, c2_r, c3_r;
  logic signed [31:0] p_axbx_r, p_ayby_r, p_axby_r, p_bxay_r;
  logic signed [XW-1:0] dot_r, crs_r, x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  // quadrant pre-rotation so that x is not negative
  always_comb begin
    x_nxt = dot_r;
    y_nxt = crs_r;
    z_nxt = '0;
    if (dot_r < 0) begin
      if (crs_r >= 0) begin
        x_nxt = crs_r;
        y_nxt = -dot_r;
        z_nxt = AngQuarter;
      end else begin
        x_nxt = -crs_r;
        y_nxt = dot_r;
        z_nxt = -AngQuarter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (adv) begin
      c1_r.valid <= in_valid;
      c1_r.invalid <= ((ax == 16'sd0) && (ay == 16'sd0)) || ((bx == 16'sd0) && (by == 16'sd0));
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_axbx_r <= ax * bx;
      p_ayby_r <= ay * by;
      p_axby_r <= ax * by;
      p_bxay_r <= bx * ay;
      dot_r <= XW'(p_axbx_r) + XW'(p_ayby_r);
      crs_r <= XW'(p_axby_r) - XW'(p_bxay_r);
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = c3_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

FILE: src/vafc_norm.sv
module vafc_norm import vafc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  ctl_t                 ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output ctl_t                 ctl_o,
  output logic signed [NW-1:0] x_o,
  output logic signed [NW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  ctl_t ca_r, cb_r;
  logic signed [XW-1:0] xa_r, ya_r;
  logic signed [ZW-1:0] za_r, zb_r;
  logic [KW-1:0] k_r, k_nxt;
  logic signed [NW-1:0] xb_r, yb_r;
  logic [XW-1:0] m;

  // highest set bit of |x| | |y| decides the doubling count
  always_comb begin
    m = (x_i < 0 ? XW'(-x_i) : XW'(x_i)) | (y_i < 0 ? XW'(-y_i) : XW'(y_i));
    k_nxt = '0;
    for (int p = 0; p < XW; p++) begin
      if (m[p]) k_nxt = (p >= NormBit) ? KW'(0) : KW'(NormBit - p);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
      cb_r <= '0;
    end else if (adv) begin
      ca_r <= ctl_i;
      cb_r <= ca_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa_r <= x_i;
      ya_r <= y_i;
      za_r <= z_i;
      k_r <= k_nxt;
      xb_r <= NW'(xa_r) <<< k_r;
      yb_r <= NW'(ya_r) <<< k_r;
      zb_r <= za_r;
    end
  end

  assign ctl_o = cb_r;
  assign x_o = xb_r;
  assign y_o = yb_r;
  assign z_o = zb_r;
endmodule

FILE: src/vafc_cordic_stage.sv
module vafc_cordic_stage import vafc_pkg::*; #(
  parameter int I = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  ctl_t                 ctl_i,
  input  logic signed [NW-1:0] x_i,
  input  logic signed [NW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output ctl_t                 ctl_o,
  output logic signed [NW-1:0] x_o,
  output logic signed [NW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  ctl_t c_r;
  logic signed [NW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r, a;

  assign xs = x_i >>> I;
  assign ys = y_i >>> I;
  assign a = atan_deg(5'(I));

  always_ff @(posedge clk) begin
    if (!rst_n) c_r <= '0;
    else if (adv) c_r <= ctl_i;
  end

  // rotate towards the x axis
  always_ff @(posedge clk) begin
    if (adv) begin
      if (y_i >= 0) begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + a;
      end else begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - a;
      end
    end
  end

  assign ctl_o = c_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

FILE: src/vector_angle_full_circle.sv
// counterclockwise angle from a first 2d vector to a second, full circle
// input channel: one transfer carries both vectors, signed q8.8
// output channel: angle in 1/128 degree, 0 to 46079, plus an invalid flag
// a zero-length vector on either side gives angle 0 with invalid set
// pipeline from input transfer to output valid: 3 front stages for
// products, sums and quadrant pre-rotation, 2 normalisation stages,
// one per micro-rotation, one for the final fold
// throughput: one pair per cycle while the receiver keeps up, every stage is its own register
// the whole pipe advances together; a stalled receiver freezes it and
// in_tready falls only while a result waits untaken
// reset clears every valid bit; payload registers are not reset
module vector_angle_full_circle import vafc_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_x, first_y, second_x, second_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // angle_deg
  output logic [0:0]  out_tuser   // invalid
);
  logic adv;
  ctl_t f_ctl, n_ctl;
  logic signed [XW-1:0] f_x, f_y;
  logic signed [ZW-1:0] f_z, n_z;
  logic signed [NW-1:0] n_x, n_y;

  ctl_t c_ctl [CORDIC_STAGES+1];
  logic signed [NW-1:0] c_x [CORDIC_STAGES+1];
  logic signed [NW-1:0] c_y [CORDIC_STAGES+1];
  logic signed [ZW-1:0] c_z [CORDIC_STAGES+1];

  logic out_valid_r;
  logic [15:0] angle_r;
  logic inv_r;
  logic signed [ZW-1:0] zf;
  logic [16:0] q;
  logic [15:0] angle_nxt;

  // pipe moves whenever the output slot is free or being taken
  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv;

  vafc_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_tvalid),
    .ax(in_tdata[15:0]), .ay(in_tdata[31:16]),
    .bx(in_tdata[47:32]), .by(in_tdata[63:48]),
    .ctl_o(f_ctl), .x_o(f_x), .y_o(f_y), .z_o(f_z)
  );

  vafc_norm u_norm (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .ctl_i(f_ctl), .x_i(f_x), .y_i(f_y), .z_i(f_z),
    .ctl_o(n_ctl), .x_o(n_x), .y_o(n_y), .z_o(n_z)
  );

  assign c_ctl[0] = n_ctl;
  assign c_x[0] = n_x;
  assign c_y[0] = n_y;
  assign c_z[0] = n_z;

  // one micro-rotation per stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    vafc_cordic_stage #(.I(g)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .ctl_i(c_ctl[g]), .x_i(c_x[g]), .y_i(c_y[g]), .z_i(c_z[g]),
      .ctl_o(c_ctl[g+1]), .x_o(c_x[g+1]), .y_o(c_y[g+1]), .z_o(c_z[g+1])
    );
  end

  // fold to [0, 360), round half up to 1/128 degree, wrap 360 to 0
  always_comb begin
    zf = (c_z[CORDIC_STAGES] < 0) ? c_z[CORDIC_STAGES] + AngFull : c_z[CORDIC_STAGES];
    q = 17'((ZW'(zf) + ZW'(256)) >> 9);
    if (q >= OutFull) q = q - OutFull;
    angle_nxt = c_ctl[CORDIC_STAGES].invalid ? 16'd0 : q[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= c_ctl[CORDIC_STAGES].valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= angle_nxt;
      inv_r <= c_ctl[CORDIC_STAGES].invalid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = angle_r;
  assign out_tuser = inv_r;
endmodule

FILE: src/vafc_checker.sv
`include "vector_angle_full_circle_defines.svh"
module vafc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);
  `VAFC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output changed")
  `VAFC_ASSERT_NOW(a_inv_zero, out_tvalid && out_tuser[0], out_tdata == 16'd0, "invalid result with nonzero angle")
  `VAFC_ASSERT_NOW(a_range, out_tvalid, out_tdata < 16'd46080, "angle out of range")
  `VAFC_ASSERT_NOW(a_ready, !out_tvalid || out_tready, in_tready, "input blocked with free output")
endmodule

bind vector_angle_full_circle vafc_checker u_vafc_checker (.*);

FILE: test/testbench.sv
// angle between two 2d vectors: directed extremes, then random pairs under several
// idle and stall mixes, each result checked against a bit-exact cordic model
module testbench;

  localparam int Stages = 20;
  localparam int Latency = Stages + 6;

  // expected angle and flag for one accepted pair
  typedef struct {
    logic [15:0] angle;
    logic        bad;
  } angle_t;

  // bit-exact angle model, 1/128 degree
  function automatic angle_t predict_angle(logic [63:0] d);
    angle_t r;
    longint ax, ay, bx, by, x, y, z, t, xs, ys, q;
    longint tab [0:31];
    int i;
    tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    bx = longint'($signed(d[47:32]));
    by = longint'($signed(d[63:48]));
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      r.angle = '0;
      r.bad = 1'b1;
      return r;
    end
    x = ax * bx + ay * by;
    y = ax * by - bx * ay;
    z = 0;
    // quarter turn so that x is not negative
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (i = 0; i < Stages && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - tab[i];
      end
    end
    if (z < 0) z = z + 360 * 65536;
    q = (z + 256) >>> 9;
    if (q >= 46080) q = q - 46080;
    r.angle = q[15:0];
    r.bad = 1'b0;
    return r;
  endfunction

  class angle_scoreboard;
    angle_t pending[$];
    int errors;

    function void note_pair(logic [63:0] d);
      pending.push_back(predict_angle(d));
    endfunction

    function void check_angle(logic [15:0] angle, logic bad);
      angle_t e;
      if (pending.size() == 0) begin
        $error("result with no pair outstanding: angle %0d", angle);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (angle !== e.angle) begin
        $error("angle_deg expected %0d actual %0d", e.angle, angle);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("invalid expected %0d actual %0d", e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // first_x, first_y, second_x, second_y
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // angle_deg
  logic [0:0]  out_tuser;       // invalid

  angle_scoreboard board = new();
  int send_idle = 0;    // percent of cycles the sender holds off
  int recv_stall = 0;   // percent of cycles the receiver stalls

  always #4 clk = ~clk;

  vector_angle_full_circle #(.CORDIC_STAGES(Stages)) dut (.*);

  // result side: random stall, check each transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_angle(out_tdata, out_tuser[0]);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // one pair per call, held until its transfer; valid stays up for the next pair
  task automatic send_pair(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx, logic [15:0] by);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {by, bx, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pair({by, bx, ay, ax});
  endtask

  // random component: mostly full range, sometimes tiny, zero or extreme
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'($signed($urandom_range(8)) - 4);
      2: return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_pairs(int n);
    logic [15:0] ax, ay, bx, by;
    repeat (n) begin
      ax = rand_comp(); ay = rand_comp(); bx = rand_comp(); by = rand_comp();
      // collinear pairs now and then: same or opposite direction
      if ($urandom_range(7) == 0) begin
        bx = ($urandom_range(1) != 0) ? ax : -ax;
        by = (bx == ax) ? ay : -ay;
      end
      send_pair(ax, ay, bx, by);
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero vectors, axes, collinear, extremes
    send_pair(16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_pair(16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h0100, 16'h0000, 16'h0100, 16'h0000);
    send_pair(16'h0100, 16'h0000, 16'hff00, 16'h0000);
    send_pair(16'h0100, 16'h0000, 16'h0000, 16'h0100);
    send_pair(16'h0100, 16'h0000, 16'h0000, 16'hff00);
    send_pair(16'h0100, 16'h0100, 16'hff00, 16'h0100);
    send_pair(16'h0100, 16'h0000, 16'hff00, 16'hffff);
    send_pair(16'h0100, 16'h0000, 16'hff00, 16'h0001);
    send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_pair(16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_pair(16'h0001, 16'h0001, 16'hffff, 16'h0000);
    send_pair(16'hffff, 16'hffff, 16'h0001, 16'h0001);
    send_pair(16'h7fff, 16'h0001, 16'h7fff, 16'hffff);
    send_pair(16'h7fff, 16'h0000, 16'h7fff, 16'h0001);
    send_pair(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    // sender waits for every result before going on
    drain();
    random_pairs(250);
    send_idle = 65; recv_stall = 0;
    random_pairs(250);
    send_idle = 0; recv_stall = 65;
    random_pairs(250);
    send_idle = 25; recv_stall = 25;
    random_pairs(250);
    drain();
    repeat (Latency + 4) @(posedge clk);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // generous guard: 1000 pairs with heavy idling fit well inside this
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: vector_angle_full_circle.f
+incdir+src
src/vafc_pkg.sv
src/vafc_front.sv
src/vafc_norm.sv
src/vafc_cordic_stage.sv
src/vector_angle_full_circle.sv
src/vafc_checker.sv
test/testbench.sv
